FILE: hdl/serial_line_framer_parity_top_defines.svh
// assertion macros for the serial line framer
// used by the top level only; expects aclk and aresetn in scope
`ifndef SERIAL_LINE_FRAMER_PARITY_TOP_DEFINES_SVH
`define SERIAL_LINE_FRAMER_PARITY_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SLFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slfp assertion failed");

// antecedent implies consequent in the next cycle
`define SLFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slfp assertion failed");

`endif

FILE: hdl/slfp_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the serial line framer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slfp_pkg;

    localparam int MAX_LEN   = 32;
    localparam int OUT_SLOTS = 32;
    localparam int CAPACITY  = (MAX_LEN < OUT_SLOTS) ? MAX_LEN : OUT_SLOTS;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
    localparam logic [5:0]       LEN_CAP = 6'(CAPACITY);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PARITY_MODE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_MODE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIXED_LENGTH = 2'd2;

    // parity modes
    localparam logic [1:0] PM_NONE  = 2'd0;
    localparam logic [1:0] PM_STRIP = 2'd1;
    localparam logic [1:0] PM_EVEN  = 2'd2;
    localparam logic [1:0] PM_ODD   = 2'd3;

    // frame modes
    localparam logic [1:0] FM_FIXED = 2'd0;
    localparam logic [1:0] FM_CR    = 2'd1;
    localparam logic [1:0] FM_CRLF  = 2'd2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] BIT7  = 8'h80;

    typedef struct packed {
        logic accept;
        logic push_cr;
        logic push_data;
        logic start_emit;
        logic read;
        logic advance;
    } slfp_cmd_t;

    typedef struct packed {
        logic msg_end;
        logic out_last;
    } slfp_status_t;

endpackage

`default_nettype wire

FILE: hdl/slfp_ctrl.sv
// controller state machine: sequences buffer writes, message end check
// and readout; depends on slfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfp_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire slfp_pkg::slfp_status_t status,
    output slfp_pkg::slfp_cmd_t        cmd
);
    import slfp_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_HOLD_CR = 6'b000010,
        ST_STORE   = 6'b000100,
        ST_CHECK   = 6'b001000,
        ST_READ    = 6'b010000,
        ST_SEND    = 6'b100000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_HOLD_CR;
                end
            end
            ST_HOLD_CR: begin
                cmd.push_cr = 1'b1;
                state_next  = ST_STORE;
            end
            ST_STORE: begin
                cmd.push_data = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.msg_end) begin
                    cmd.start_emit = 1'b1;
                    state_next     = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (out_ready) begin
                    if (status.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);

endmodule

`default_nettype wire

FILE: hdl/slfp_datapath.sv
// datapath: config registers, parity stage, framing decision,
// message buffer, counters and readout registers; depends on slfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module slfp_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [slfp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [slfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [7:0]                          in_byte,
    input  wire slfp_pkg::slfp_cmd_t                 cmd,
    output slfp_pkg::slfp_status_t                   status,
    output logic [7:0]                               out_byte,
    output logic [4:0]                               out_index,
    output logic                                     out_empty,
    output logic                                     out_perr,
    output logic                                     out_miss,
    output logic                                     out_ovf
);
    import slfp_pkg::*;

    // configuration
    logic [1:0] parity_mode_reg;
    logic [1:0] frame_mode_reg;
    logic [5:0] fixed_length_reg;

    // message state
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       prev_reg;
    logic             perr_reg;
    logic             ovf_reg;

    // item latched at accept
    logic [7:0] d_reg;
    logic       need_cr_reg;
    logic       push_d_reg;
    logic       term_reg;
    logic       fixed_reg;
    logic       miss_reg;

    // readout
    logic [7:0]       store_mem [CAPACITY];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             emit_empty_reg;
    logic             emit_perr_reg;
    logic             emit_miss_reg;
    logic             emit_ovf_reg;

    // parity stage and framing decision on the incoming byte
    logic       odd_ones;
    logic       perr_hit;
    logic [7:0] d_in;
    logic       need_cr_in;
    logic       push_d_in;
    logic       term_in;
    logic       fixed_in;
    logic       miss_in;
    logic [7:0] prev_next;

    logic [5:0]       lim;
    logic             wr_req;
    logic [7:0]       wr_data;
    logic             room;
    logic [CNT_W-1:0] cnt_dec;

    assign odd_ones = ^in_byte;

    always_comb begin
        perr_hit = 1'b0;
        d_in     = in_byte & ~BIT7;
        unique case (parity_mode_reg)
            PM_NONE:  d_in = in_byte;
            PM_STRIP: perr_hit = 1'b0;
            PM_EVEN:  perr_hit = odd_ones;
            PM_ODD:   perr_hit = ~odd_ones;
        endcase
    end

    always_comb begin
        need_cr_in = 1'b0;
        push_d_in  = 1'b0;
        term_in    = 1'b0;
        fixed_in   = 1'b0;
        miss_in    = 1'b0;
        prev_next  = 8'h00;
        unique case (frame_mode_reg) inside
            FM_FIXED: begin
                push_d_in = 1'b1;
                fixed_in  = 1'b1;
            end
            FM_CRLF: begin
                if (d_in == CH_LF) begin
                    term_in = 1'b1;
                    miss_in = (prev_reg != CH_CR);
                end else begin
                    need_cr_in = (prev_reg == CH_CR);
                    push_d_in  = (d_in != CH_CR);
                    prev_next  = d_in;
                end
            end
            default: begin
                // cr terminated, also the unused code
                term_in   = (d_in == CH_CR);
                push_d_in = (d_in != CH_CR);
            end
        endcase
    end

    // effective fixed length: zero acts as one, clipped to the buffer size
    always_comb begin
        if (fixed_length_reg == 6'd0) begin
            lim = 6'd1;
        end else if (fixed_length_reg > LEN_CAP) begin
            lim = LEN_CAP;
        end else begin
            lim = fixed_length_reg;
        end
    end

    assign wr_req  = (cmd.push_cr && need_cr_reg) || (cmd.push_data && push_d_reg);
    assign wr_data = cmd.push_cr ? CH_CR : d_reg;
    assign room    = (count_reg < CNT_CAP);
    assign cnt_dec = count_reg - CNT_W'(1);

    assign status.msg_end  = term_reg || (fixed_reg && (6'(count_reg) >= lim));
    assign status.out_last = emit_empty_reg || (rd_idx_reg == last_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_mode_reg  <= PM_NONE;
            frame_mode_reg   <= FM_CR;
            fixed_length_reg <= LEN_CAP;
            count_reg        <= '0;
            prev_reg         <= 8'h00;
            perr_reg         <= 1'b0;
            ovf_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_PARITY_MODE:  parity_mode_reg  <= cfg_wdata[1:0];
                    REG_FRAME_MODE:   frame_mode_reg   <= cfg_wdata[1:0];
                    REG_FIXED_LENGTH: fixed_length_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                prev_reg <= prev_next;
                if (perr_hit) begin
                    perr_reg <= 1'b1;
                end
            end
            if (wr_req) begin
                if (room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.start_emit) begin
                count_reg <= '0;
                prev_reg  <= 8'h00;
                perr_reg  <= 1'b0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            d_reg       <= d_in;
            need_cr_reg <= need_cr_in;
            push_d_reg  <= push_d_in;
            term_reg    <= term_in;
            fixed_reg   <= fixed_in;
            miss_reg    <= miss_in;
        end
        if (wr_req && room) begin
            store_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        if (cmd.start_emit) begin
            emit_empty_reg <= (count_reg == '0);
            last_idx_reg   <= cnt_dec[IDX_W-1:0];
            emit_perr_reg  <= perr_reg;
            emit_miss_reg  <= miss_reg;
            emit_ovf_reg   <= ovf_reg;
            rd_idx_reg     <= '0;
        end
        if (cmd.read) begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
        if (cmd.advance) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    assign out_byte  = emit_empty_reg ? 8'h00 : rd_data_reg;
    assign out_index = 5'(rd_idx_reg);
    assign out_empty = emit_empty_reg;
    assign out_perr  = emit_perr_reg;
    assign out_miss  = emit_miss_reg;
    assign out_ovf   = emit_ovf_reg;

endmodule

`default_nettype wire

FILE: hdl/serial_line_framer_parity_top.sv
// top level of the serial line framer: stream ports, config port,
// controller and datapath; depends on slfp_pkg, slfp_ctrl, slfp_datapath
`timescale 1ns / 1ps
`default_nettype none

`include "serial_line_framer_parity_top_defines.svh"

// serial line framer with parity check. each received byte goes through a
// parity stage (pass, clear bit 7, or even/odd check then clear bit 7) and
// a framing stage (fixed length, cr terminated, or cr lf terminated with a
// missing-cr flag). data bytes collect in a 32-entry message buffer; when a
// message ends, its bytes come out in order on the m_axis side with index,
// tlast and the message flags, or one empty-message item if none were held.
// bytes past the buffer size are dropped and flagged as overflow.
// timing: one item at a time. an item that ends no message passes through
// accept, held-cr write, data write and end check, as the controller
// sequences up to two writes into the single-port buffer. an item that ends
// a message adds a buffer read, then the registered result, for each result
// plus any downstream stall; s_axis_tready is low meanwhile.
// config writes take effect at once and are meant for idle periods only.
// after reset the buffer needs no clearing; the block is ready at once.

module serial_line_framer_parity_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [slfp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [slfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [slfp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] raw_byte
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] out_byte, [12:8] byte_index, [15:13] zero
    output logic [slfp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast,  // last
    // [0] empty_message, [1] parity_error, [2] missing_cr, [3] overflow
    output logic [slfp_pkg::OUT_USER_W-1:0]        m_axis_tuser
);
    import slfp_pkg::*;

    slfp_cmd_t    cmd;
    slfp_status_t status;

    logic [7:0] out_byte;
    logic [4:0] out_index;
    logic       out_empty;
    logic       out_perr;
    logic       out_miss;
    logic       out_ovf;

    // sequencing of accept, buffer writes, end check and readout
    slfp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // config, parity and framing logic, message buffer
    slfp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (out_byte),
        .out_index (out_index),
        .out_empty (out_empty),
        .out_perr  (out_perr),
        .out_miss  (out_miss),
        .out_ovf   (out_ovf)
    );

    // pack the result item
    assign m_axis_tdata = {3'b000, out_index, out_byte};
    assign m_axis_tlast = status.out_last;
    assign m_axis_tuser = {out_ovf, out_miss, out_perr, out_empty};

    // no new byte is taken while a message is being read out
    `SLFP_ASSERT_SAME(a_no_accept_in_readout, m_axis_tvalid, !s_axis_tready)
    // an accepted byte blocks the input until its processing is done
    `SLFP_ASSERT_NEXT(a_accept_blocks, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // each further result needs a buffer read state first, with tvalid low
    `SLFP_ASSERT_NEXT(a_read_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                      !m_axis_tvalid)
    // an empty message is one item with zero byte and index
    `SLFP_ASSERT_SAME(a_empty_single, m_axis_tvalid && m_axis_tuser[0],
                      m_axis_tlast && (m_axis_tdata == '0))

endmodule

`default_nettype wire
